@@ hw/rtl/kdas_pkg.sv @@
// ----------------------------------------------------------------------------
// kdas_pkg: key debounce / auto-repeat / press stack definitions
// Shared widths, operation codes and stack sizing for the key block.
// ----------------------------------------------------------------------------
package kdas_pkg;

    localparam int OP_W       = 2;
    localparam int MASK_W     = 6;
    localparam int KEY_W      = 3;
    localparam int HOLD_W     = 4;
    localparam int LEVEL_W    = 4;
    localparam int CFG_W      = 4;
    localparam int NUM_KEYS   = 6;

    localparam int STACK_DEPTH = 8;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [HOLD_W-1:0] HOLD_MAX = '1;

    localparam logic [CFG_W-1:0] CONFIRM_RST = CFG_W'(1);
    localparam logic [CFG_W-1:0] LIMIT_RST   = CFG_W'(10);
    localparam logic [CFG_W-1:0] RELOAD_RST  = CFG_W'(5);

    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 2'd0,
        OP_POP   = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        REG_CONFIRM = 2'd0,
        REG_LIMIT   = 2'd1,
        REG_RELOAD  = 2'd2
    } reg_idx_t;

endpackage

@@ hw/rtl/kdas_if.sv @@
// ----------------------------------------------------------------------------
// kdas_if: valid/ready channels of the key block
// Input channel carries op and key mask; output channel carries the result.
// ----------------------------------------------------------------------------
interface kdas_in_if;
    import kdas_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [MASK_W-1:0] key_mask;

    modport source (output valid, output op, output key_mask, input ready);
    modport sink   (input valid, input op, input key_mask, output ready);
endinterface

interface kdas_out_if;
    import kdas_pkg::*;

    logic               valid;
    logic               ready;
    logic [KEY_W-1:0]   popped_key;
    logic [KEY_W-1:0]   held_key;
    logic               beep;
    logic [LEVEL_W-1:0] stack_level;

    modport source (output valid, output popped_key, output held_key, output beep,
                    output stack_level, input ready);
    modport sink   (input valid, input popped_key, input held_key, input beep,
                    input stack_level, output ready);
endinterface

@@ hw/rtl/key_debounce_autorepeat_stack.sv @@
// ----------------------------------------------------------------------------
// key_debounce_autorepeat_stack: keypad debounce with auto-repeat press stack
//
// in_ch takes one beat per item: op 0 is a scan tick with a 6-bit key mask,
// op 1 pops the newest key code, op 2 clears the press stack, op 3 is a no-op.
// out_ch returns one beat per item: popped key, confirmed held key, beep
// (a press fired on this tick, also with the stack full) and the stack
// level after the item. A beat goes into an input register, is evaluated
// against the debounce state and lands in the result register; one item
// per cycle is sustained while out_ch does not stall.
// When out_ch stalls, the result register holds and in_ch keeps accepting
// until the input register is also full, then ready drops.
// The APB port writes confirm_count (0x0), repeat_limit (0x4) and
// repeat_reload (0x8); write only while no item is in flight.
// Reset clears key tracking and the stack level and loads the register
// defaults 1, 10 and 5; stack entries are not cleared. in_ch.ready is low
// while reset is held.
// ----------------------------------------------------------------------------
module key_debounce_autorepeat_stack
(
    input  logic                         clk,
    input  logic                         rst_n,
    kdas_in_if.sink                      in_ch,
    kdas_out_if.source                   out_ch,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [kdas_pkg::APB_AW-1:0]  paddr,
    input  logic [kdas_pkg::APB_DW-1:0]  pwdata,
    output logic [kdas_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);
    import kdas_pkg::*;

    // config registers
    logic [CFG_W-1:0] confirm_reg, limit_reg, reload_reg;
    logic             cfg_wr;
    reg_idx_t         cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            confirm_reg <= CONFIRM_RST;
            limit_reg   <= LIMIT_RST;
            reload_reg  <= RELOAD_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_CONFIRM: confirm_reg <= pwdata[CFG_W-1:0];
                REG_LIMIT:   limit_reg   <= pwdata[CFG_W-1:0];
                REG_RELOAD:  reload_reg  <= pwdata[CFG_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (cfg_idx)
            REG_CONFIRM: prdata = APB_DW'(confirm_reg);
            REG_LIMIT:   prdata = APB_DW'(limit_reg);
            REG_RELOAD:  prdata = APB_DW'(reload_reg);
            default:     prdata = '0;
        endcase
    end

    // handshake
    logic              in_valid_reg;
    logic [OP_W-1:0]   in_op_reg;
    logic [MASK_W-1:0] in_mask_reg;
    logic              out_valid_reg;
    logic              advance;
    logic              in_take;

    assign advance     = in_valid_reg & (~out_valid_reg | out_ch.ready);
    assign in_ch.ready = rst_n & (~in_valid_reg | advance);
    assign in_take     = in_ch.valid & in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ch.ready)
                in_valid_reg <= in_ch.valid;
            if (~out_valid_reg | out_ch.ready)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_op_reg   <= in_ch.op;
            in_mask_reg <= in_ch.key_mask;
        end
    end

    // key state
    logic [KEY_W-1:0]  cand_reg, cand_next;
    logic [HOLD_W-1:0] hold_reg, hold_next;
    logic [KEY_W-1:0]  rep_reg, rep_next;
    logic [KEY_W-1:0]  cur_reg, cur_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [KEY_W-1:0]  stack_mem [STACK_DEPTH];

    logic [KEY_W-1:0]  code;
    logic [HOLD_W-1:0] hold_inc;
    logic              push;
    logic              push_wr;
    logic [IDX_W-1:0]  top_idx;
    logic [KEY_W-1:0]  popped;
    op_t               op;

    assign op       = op_t'(in_op_reg);
    assign hold_inc = (hold_reg == HOLD_MAX) ? HOLD_MAX : hold_reg + HOLD_W'(1);
    assign top_idx  = IDX_W'(count_reg - CNT_W'(1));

    always_comb
    begin
        code = '0;
        for (int i = 0; i < NUM_KEYS; i++)
        begin
            if (in_mask_reg == MASK_W'(1 << i))
                code = KEY_W'(i + 1);
        end
    end

    always_comb
    begin
        cand_next  = cand_reg;
        hold_next  = hold_reg;
        rep_next   = rep_reg;
        cur_next   = cur_reg;
        count_next = count_reg;
        push       = 1'b0;
        popped     = '0;
        case (op)
            OP_TICK:
            begin
                if (code == '0)
                begin
                    cand_next = '0;
                    hold_next = '0;
                    rep_next  = '0;
                    cur_next  = '0;
                end
                else if (cand_reg != code)
                begin
                    cand_next = code;
                    hold_next = '0;
                end
                else if (hold_reg < confirm_reg)
                begin
                    hold_next = hold_inc;
                end
                else
                begin
                    if (rep_reg != code)
                        push = 1'b1;
                    else if (hold_reg >= limit_reg)
                    begin
                        hold_next = reload_reg;
                        push      = 1'b1;
                    end
                    else
                        hold_next = hold_inc;
                    rep_next = code;
                    cur_next = code;
                end
                if (push && count_reg < CNT_W'(STACK_DEPTH))
                    count_next = count_reg + CNT_W'(1);
            end
            OP_POP:
            begin
                if (count_reg != '0)
                begin
                    count_next = count_reg - CNT_W'(1);
                    popped     = stack_mem[top_idx];
                end
            end
            OP_CLEAR:
                count_next = '0;
            default: ;
        endcase
    end

    assign push_wr = advance & push & (count_reg < CNT_W'(STACK_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_reg  <= '0;
            hold_reg  <= '0;
            rep_reg   <= '0;
            cur_reg   <= '0;
            count_reg <= '0;
        end
        else if (advance)
        begin
            cand_reg  <= cand_next;
            hold_reg  <= hold_next;
            rep_reg   <= rep_next;
            cur_reg   <= cur_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_wr)
            stack_mem[IDX_W'(count_reg)] <= code;
    end

    // result register
    logic [KEY_W-1:0]   popped_reg;
    logic [KEY_W-1:0]   held_reg;
    logic               beep_reg;
    logic [LEVEL_W-1:0] level_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            popped_reg <= popped;
            held_reg   <= cur_next;
            beep_reg   <= push;
            level_reg  <= LEVEL_W'(count_next);
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.popped_key  = popped_reg;
    assign out_ch.held_key    = held_reg;
    assign out_ch.beep        = beep_reg;
    assign out_ch.stack_level = level_reg;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count above depth");

    a_beep_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && beep_reg |-> held_reg != '0 && popped_reg == '0)
        else $error("beep without a held key");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        advance && op == OP_CLEAR |=> count_reg == '0)
        else $error("stack not cleared");

    a_rep_cur: assert property (@(posedge clk) disable iff (!rst_n)
        rep_reg == cur_reg)
        else $error("reported and current key differ");

endmodule
